FILE: rtl/rolling_hash_pattern_match_unit_assert.svh
// assertion macros for the rolling hash pattern match unit
`ifndef ROLLING_HASH_PATTERN_MATCH_UNIT_ASSERT_SVH
`define ROLLING_HASH_PATTERN_MATCH_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RHPM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhpm check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define RHPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhpm check failed: next-cycle implication");

`endif

FILE: rtl/rhpm_pkg.sv
// shared types, constants and helpers of the rolling hash pattern match unit
package rhpm_pkg;

	localparam int LEN_W     = 5;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LENGTH   = 2'd0,
		REG_CHARS_LO = 2'd1,
		REG_CHARS_HI = 2'd2
	} cfg_reg_t;

	// match run handed from the window to the output sequencer
	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] len_m1;
	} run_req_t;

	// byte value mod 3: 4^k is 1 mod 3, so sum the base-4 digits first
	function automatic logic [1:0] mod3_byte(input logic [7:0] b);
		logic [3:0] s;
		logic [1:0] m;
		s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
		case (s) inside
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
			default:                       m = 2'd2;
		endcase
		return m;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
		input logic [LEN_W-1:0] max_len);
		logic [LEN_W-1:0] c;
		if (v == '0) begin
			c = LEN_W'(1);
		end else if (v > max_len) begin
			c = max_len;
		end else begin
			c = v;
		end
		return c;
	endfunction

endpackage

FILE: rtl/rhpm_window.sv
// residue window, target residues, position count and match detection
module rhpm_window import rhpm_pkg::*; #(
	parameter int MAX_PATTERN   = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               text_byte,
	input  logic                     first_of_text,
	input  logic [LEN_W-1:0]         pattern_length,
	input  logic [CFG_W-1:0]         pattern_chars_low,
	input  logic [CFG_W-1:0]         pattern_chars_high,
	output run_req_t                 req,
	output logic [POSITION_BITS-1:0] start_pos
);

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN);

	logic [1:0]               win_q [MAX_PATTERN];
	logic [1:0]               tgt_q [MAX_PATTERN];
	logic [1:0]               win_d [MAX_PATTERN];
	logic [1:0]               tgt_d [MAX_PATTERN];
	logic [1:0]               base_w [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]   eq;
	logic [LEN_W-1:0]         len_q, fill_q, base_len, base_fill, fill_d;
	logic [POSITION_BITS-1:0] pos_q, base_pos, pos_d;
	logic [1:0]               res;
	logic                     full;

	always_comb begin
		res       = mod3_byte(text_byte);
		base_len  = first_of_text ? clamp_len(pattern_length, MaxLen) : len_q;
		base_fill = first_of_text ? '0 : fill_q;
		base_pos  = first_of_text ? '0 : pos_q;
		pos_d     = base_pos + POSITION_BITS'(1);
		full      = base_fill >= base_len;
		fill_d    = full ? base_fill : base_fill + LEN_W'(1);
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_slot
		logic [1:0] up;
		logic [7:0] pat_byte;

		assign base_w[i] = first_of_text ? 2'd0 : win_q[i];

		if (i < MAX_PATTERN - 1) begin : g_up
			assign up = base_w[i+1];
		end else begin : g_top
			assign up = 2'd0;
		end

		if (i < 8) begin : g_lo
			assign pat_byte = pattern_chars_low[8*i +: 8];
		end else begin : g_hi
			assign pat_byte = pattern_chars_high[8*(i-8) +: 8];
		end

		always_comb begin
			win_d[i] = base_w[i];
			if (!full) begin
				if (base_fill == LEN_W'(i)) begin
					win_d[i] = res;
				end
			end else if (base_len == LEN_W'(i + 1)) begin
				win_d[i] = res;
			end else if (LEN_W'(i + 1) < base_len) begin
				// window slides toward the oldest slot
				win_d[i] = up;
			end
			if (first_of_text) begin
				tgt_d[i] = (LEN_W'(i) < base_len) ? mod3_byte(pat_byte) : 2'd0;
			end else begin
				tgt_d[i] = tgt_q[i];
			end
			eq[i] = win_d[i] == tgt_d[i];
		end
	end

	// base-3 digits are unique, so hash equality is digit-wise equality
	assign req.hit    = (fill_d == base_len) && (&eq);
	assign req.len_m1 = CNT_W'(base_len - LEN_W'(1));
	assign start_pos  = pos_d - POSITION_BITS'(base_len) + POSITION_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= 2'd0;
				tgt_q[i] <= 2'd0;
			end
			len_q  <= LEN_W'(1);
			fill_q <= '0;
			pos_q  <= '0;
		end else if (step) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_d[i];
				tgt_q[i] <= tgt_d[i];
			end
			len_q  <= base_len;
			fill_q <= fill_d;
			pos_q  <= pos_d;
		end
	end

endmodule

FILE: rtl/rhpm_emitter.sv
// output register that plays out the positions of one matching window
module rhpm_emitter import rhpm_pkg::*; #(
	parameter int POSITION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  run_req_t                 req,
	input  logic [POSITION_BITS-1:0] start_pos,
	output logic                     free,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              match_position,
	output logic                     last_of_run
);

	logic                     busy_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [POSITION_BITS-1:0] pos_q;

	assign last_of_run    = cnt_q == '0;
	assign free           = !busy_q || (out_ready && last_of_run);
	assign out_valid      = busy_q;
	assign match_position = 32'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load && req.hit) begin
			busy_q <= 1'b1;
			cnt_q  <= req.len_m1;
		end else if (busy_q && out_ready) begin
			if (last_of_run) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && req.hit) begin
			pos_q <= start_pos;
		end else if (busy_q && out_ready) begin
			pos_q <= pos_q + POSITION_BITS'(1);
		end
	end

endmodule

FILE: rtl/rolling_hash_pattern_match_unit.sv
// Rolling hash pattern matcher (Rabin-Karp on byte residues mod 3). Each text byte
// passes an input register and is folded from there into the residue window, so a
// byte can be taken every clock while no match run is playing out. A byte with
// first_of_text restarts the position count at 1, latches the window length and the
// target from the pattern registers. When the full window equals the target, the
// 1-based positions of its N bytes leave the output register one per cycle while
// out_ready is high, oldest first, last one flagged; while such a run plays out the
// input stage holds, and output stalls hold it longer. With the output side idle, a
// matching byte passes the input register, then its first position is loaded into
// the output register and presented. Pattern registers take effect at the next first_of_text byte.
module rolling_hash_pattern_match_unit import rhpm_pkg::*; #(
	parameter int MAX_PATTERN   = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           text_byte,
	input  logic                 first_of_text,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          match_position,
	output logic                 last_of_run,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

`include "rolling_hash_pattern_match_unit_assert.svh"

	logic [LEN_W-1:0]         pattern_length_q;
	logic [CFG_W-1:0]         chars_lo_q, chars_hi_q;
	logic                     valid_s1, first_s1;
	logic [7:0]               byte_s1;
	logic                     s1_go, emit_free;
	run_req_t                 req;
	logic [POSITION_BITS-1:0] start_pos;
	logic                     out_step;
	logic [31:0]              next_pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_W'(1);
			chars_lo_q       <= '0;
			chars_hi_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LENGTH:   pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_CHARS_LO: chars_lo_q       <= cfg_data;
				REG_CHARS_HI: chars_hi_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage drains when the emitter can take whatever this word produces
	assign s1_go    = valid_s1 && emit_free;
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= text_byte;
			first_s1 <= first_of_text;
		end
	end

	rhpm_window #(
		.MAX_PATTERN  (MAX_PATTERN),
		.POSITION_BITS(POSITION_BITS)
	) u_window (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (s1_go),
		.text_byte         (byte_s1),
		.first_of_text     (first_s1),
		.pattern_length    (pattern_length_q),
		.pattern_chars_low (chars_lo_q),
		.pattern_chars_high(chars_hi_q),
		.req               (req),
		.start_pos         (start_pos)
	);

	rhpm_emitter #(
		.POSITION_BITS(POSITION_BITS)
	) u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s1_go),
		.req           (req),
		.start_pos     (start_pos),
		.free          (emit_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_position(match_position),
		.last_of_run   (last_of_run)
	);

	assign out_step = out_valid && out_ready && !last_of_run;
	assign next_pos = match_position + 32'd1;

	`RHPM_ASSERT_NOW(a_stall_has_word, !in_ready, valid_s1)
	`RHPM_ASSERT_NOW(a_go_only_when_free, s1_go, !out_valid || (out_ready && last_of_run))
	`RHPM_ASSERT_NEXT(a_hit_starts_run, s1_go && req.hit, out_valid)
	`RHPM_ASSERT_NEXT(a_run_counts_up, out_step, out_valid && (match_position == $past(next_pos)))

endmodule
